// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// esd_pkg
// shared types, character codes and helpers of the escape sequence decoder
// ----------------------------------------------------------------------------
package esd_pkg;

    typedef enum logic [2:0] {
        MODE_TEXT    = 3'd0,
        MODE_ESCAPE  = 3'd1,
        MODE_HEX0    = 3'd2,
        MODE_HEX1    = 3'd3,
        MODE_DISCARD = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_HEX = 2'd1,
        ST_BAD_ESC = 2'd2
    } t_status;

    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NUL    = 8'd0;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
        logic       last_of_run;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic t_hex hex_value(input logic [7:0] b);
        t_hex h;
        logic [7:0] d;
        h = '{ok: 1'b0, value: 4'd0};
        d = 8'd0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            d = b - CH_ZERO;
            h = '{ok: 1'b1, value: d[3:0]};
        end else if (b >= CH_LC_A && b <= CH_LC_F) begin
            d = b - CH_LC_A + 8'd10;
            h = '{ok: 1'b1, value: d[3:0]};
        end else if (b >= CH_UC_A && b <= CH_UC_F) begin
            d = b - CH_UC_A + 8'd10;
            h = '{ok: 1'b1, value: d[3:0]};
        end
        return h;
    endfunction

endpackage

// ===== rtl/core/esd_stream_if.sv =====
// ----------------------------------------------------------------------------
// esd_stream_if
// valid/ready channels for source bytes and decoded results
// ----------------------------------------------------------------------------
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;

    modport source (output valid, output out_byte, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input last_of_run,
                    output ready);
endinterface

// ===== rtl/core/esd_decode.sv =====
// ----------------------------------------------------------------------------
// esd_decode
// decode mode state machine: turns one source byte into zero to two results
// ----------------------------------------------------------------------------
module esd_decode
    import esd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output t_push      o_push
);

    t_mode      r_mode;
    t_mode      n_mode;
    logic [3:0] r_nibble;
    logic [3:0] n_nibble;
    logic [1:0] w_count;
    t_result    w_res0;
    t_result    w_res1;
    t_hex       w_hex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_TEXT;
            r_nibble <= 4'd0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_nibble <= n_nibble;
        end
    end

    always_comb begin
        w_hex    = hex_value(i_byte);
        n_mode   = r_mode;
        n_nibble = r_nibble;
        w_count  = 2'd0;
        w_res0   = '{out_byte: i_byte, status: ST_OK, last_of_run: 1'b0};
        w_res1   = '{out_byte: i_byte, status: ST_OK, last_of_run: 1'b1};

        unique case (r_mode)
            MODE_ESCAPE: begin
                n_mode  = MODE_TEXT;
                w_count = 2'd1;
                unique case (i_byte)
                    CH_R:      w_res0.out_byte = CH_CR;
                    CH_N:      w_res0.out_byte = CH_LF;
                    CH_T:      w_res0.out_byte = CH_TAB;
                    CH_ZERO:   w_res0.out_byte = CH_NUL;
                    CH_BSLASH: w_res0.out_byte = CH_BSLASH;
                    CH_QUOTE:  w_res0.out_byte = CH_QUOTE;
                    CH_X: begin
                        if (i_eos) begin
                            w_res0.out_byte = CH_NUL;
                            w_res0.status   = ST_BAD_HEX;
                        end else begin
                            w_count = 2'd0;
                            n_mode  = MODE_HEX0;
                        end
                    end
                    default: begin
                        w_res0.status = ST_BAD_ESC;
                        n_mode        = MODE_DISCARD;
                    end
                endcase
            end
            MODE_HEX0: begin
                if (w_hex.ok) begin
                    n_nibble = w_hex.value;
                    if (i_eos) begin
                        w_count         = 2'd1;
                        w_res0.out_byte = {4'd0, w_hex.value};
                        n_mode          = MODE_TEXT;
                    end else begin
                        n_mode = MODE_HEX1;
                    end
                end else begin
                    w_count         = 2'd1;
                    w_res0.out_byte = CH_NUL;
                    w_res0.status   = ST_BAD_HEX;
                    n_mode          = MODE_DISCARD;
                end
            end
            MODE_HEX1: begin
                if (w_hex.ok) begin
                    w_count         = 2'd1;
                    w_res0.out_byte = {r_nibble, w_hex.value};
                    n_mode          = MODE_TEXT;
                end else begin
                    w_res0.out_byte = {4'd0, r_nibble};
                    if (i_byte == CH_BSLASH && !i_eos) begin
                        w_count = 2'd1;
                        n_mode  = MODE_ESCAPE;
                    end else begin
                        w_count = 2'd2;
                        n_mode  = MODE_TEXT;
                    end
                end
            end
            MODE_DISCARD: begin
                n_mode = MODE_DISCARD;
            end
            default: begin
                if (i_byte == CH_BSLASH && !i_eos) begin
                    n_mode = MODE_ESCAPE;
                end else begin
                    w_count = 2'd1;
                    n_mode  = MODE_TEXT;
                end
            end
        endcase

        if (i_eos) begin
            n_mode = MODE_TEXT;
        end
        if (n_mode != MODE_HEX1) begin
            n_nibble = 4'd0;
        end
        w_res0.last_of_run = (w_count == 2'd1);
    end

    assign o_push = '{count: (i_accept ? w_count : 2'd0), res0: w_res0, res1: w_res1};

endmodule

// ===== rtl/core/esd_result_fifo.sv =====
// ----------------------------------------------------------------------------
// esd_result_fifo
// small result queue: takes up to two results per cycle, hands out one
// ----------------------------------------------------------------------------
module esd_result_fifo
    import esd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   w_wr_next;
    logic               w_pop;

    assign w_pop     = o_valid && i_ready;
    assign w_wr_next = r_wr_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + PTR_W'(w_pop);
            r_count  <= r_count + CNT_W'(i_push.count) - CNT_W'(w_pop);
        end
    end

    assign o_space  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];

endmodule

// ===== rtl/core/escape_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// decodes a C-style escaped byte string into plain bytes and error results
// ----------------------------------------------------------------------------
// i_in carries one source byte per transaction with its end_of_string flag;
// o_out carries result transactions (out_byte, status, last_of_run).
// A source byte gives zero, one or two results; last_of_run marks the final
// result of each byte. One source byte is taken every cycle while
// i_in.ready is high. Results are registered in a four-entry queue and
// offered on o_out in order; a byte with two results gives two o_out
// transactions. i_in.ready is high while the queue holds at most two
// results, so a stalled receiver holds back input once three results wait
// and nothing is lost; bytes that give no result are still taken while
// ready is high. Mode state is registered when a byte is taken.
// Reset clears the queue and returns the decoder to normal text mode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module escape_sequence_decoder
    import esd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    esd_in_if.sink   i_in,
    esd_out_if.source o_out
);

    logic    w_accept;
    logic    w_space;
    t_push   w_push;
    t_result w_result;

    assign i_in.ready = w_space;
    assign w_accept   = i_in.valid && w_space;

    esd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in.in_byte),
        .i_eos    (i_in.end_of_string),
        .o_push   (w_push)
    );

    esd_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_space  (w_space),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (w_result)
    );

    assign o_out.out_byte    = w_result.out_byte;
    assign o_out.status      = w_result.status;
    assign o_out.last_of_run = w_result.last_of_run;

    `ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, w_push.count != 2'd0, o_out.valid)
    `ASSERT_IMPL(a_full_has_data, i_clk, i_rst_n, !i_in.ready, o_out.valid)
    `ASSERT_IMPL(a_error_is_last, i_clk, i_rst_n,
                 o_out.valid && o_out.status != ST_OK, o_out.last_of_run)

endmodule
